### rtl/ptx_pkg.sv
// ptx_pkg: shared constants, types and helpers for point_transform_4x4
// depends on nothing; used by every module under rtl/
`timescale 1ns / 1ps
`default_nettype none

package ptx_pkg;

	// datapath sizing
	localparam int DW     = 32;              // coordinate / coefficient width
	localparam int FB     = 16;              // fractional bits
	localparam int IO_W   = 32;              // port field width
	localparam int HALF_W = 32;              // coefficient slot inside a register
	localparam int REG_W  = 64;
	localparam int NREG   = 8;
	localparam int IDX_W  = $clog2(NREG);
	localparam int NCOL   = 4;
	localparam int NIN    = 3;

	localparam int PW     = 2 * DW;                          // one product
	localparam int ACC_W  = 2 * DW + 2;                      // sum of three products
	localparam int SHR_W  = ACC_W - FB;
	localparam int SW     = ((SHR_W > DW) ? SHR_W : DW) + 1; // column sum
	localparam int AW     = SW;                              // magnitude of a column sum
	localparam int HW     = AW + FB - DW;                    // dividend bits above the quotient
	localparam int CMP_W  = (HW > AW) ? HW : AW;

	localparam int QDEPTH = 2;                               // power of two
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [HALF_W-1:0] ONE = 1 << FB;

	typedef enum logic {
		OP_PERSP  = 1'b0,
		OP_AFFINE = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW0_A,
		REG_ROW0_B,
		REG_ROW1_A,
		REG_ROW1_B,
		REG_ROW2_A,
		REG_ROW2_B,
		REG_ROW3_A,
		REG_ROW3_B
	} reg_idx_t;

	typedef logic [NREG-1:0][REG_W-1:0] cfg_regs_t;
	typedef logic signed [DW-1:0] dval_t;
	typedef logic signed [SW-1:0] sval_t;

	localparam dval_t DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam dval_t DMIN = {1'b1, {(DW-1){1'b0}}};
	localparam sval_t SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam sval_t SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	typedef struct packed {
		op_t                     opcode;
		logic signed [IO_W-1:0]  x_in;
		logic signed [IO_W-1:0]  y_in;
		logic signed [IO_W-1:0]  z_in;
	} in_t;

	typedef struct packed {
		logic signed [IO_W-1:0]  x_out;
		logic signed [IO_W-1:0]  y_out;
		logic signed [IO_W-1:0]  z_out;
		logic                    zero_w;
		logic                    saturated;
	} out_t;

	// classified item between front and back
	typedef struct packed {
		op_t   op;
		dval_t x;
		dval_t y;
		dval_t z;
	} fr_t;

	// column sums leaving the mac stages
	typedef struct packed {
		op_t                  op;
		sval_t [NCOL-1:0]     s;
	} cs_t;

	function automatic logic [REG_W-1:0] reg_reset_val(reg_idx_t idx);
		logic [REG_W-1:0] one_lo;
		logic [REG_W-1:0] one_hi;
		one_lo = REG_W'(ONE);
		one_hi = one_lo << HALF_W;
		case (idx)
			REG_ROW0_A: return one_lo;
			REG_ROW1_A: return one_hi;
			REG_ROW2_B: return one_lo;
			REG_ROW3_B: return one_hi;
			default:    return '0;
		endcase
	endfunction

	// matrix element m[r][c]: two per register, lower column in the low half
	function automatic dval_t coef(cfg_regs_t m, logic [1:0] r, logic [1:0] c);
		logic [REG_W-1:0] w;
		w = m[{r, c[1]}];
		return c[0] ? dval_t'(w[HALF_W +: DW]) : dval_t'(w[0 +: DW]);
	endfunction

endpackage

`default_nettype wire

### rtl/ptx_front.sv
// ptx_front: input register, picks the working bits of each coordinate
// depends on ptx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptx_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire ptx_pkg::in_t  in_data,
	output      logic          fr_valid,
	input  wire logic          fr_ready,
	output      ptx_pkg::fr_t  fr_data
);

	logic         valid_q;
	ptx_pkg::fr_t data_q;

	assign in_ready = !valid_q || fr_ready;
	assign fr_valid = valid_q;
	assign fr_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q.op <= in_data.opcode;
			data_q.x  <= ptx_pkg::dval_t'(in_data.x_in);
			data_q.y  <= ptx_pkg::dval_t'(in_data.y_in);
			data_q.z  <= ptx_pkg::dval_t'(in_data.z_in);
		end
	end

endmodule

`default_nettype wire

### rtl/ptx_queue.sv
// ptx_queue: short flop queue between the front and the back
// depends on ptx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptx_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output      logic          push_ready,
	input  wire ptx_pkg::fr_t  push_data,
	output      logic          pop_valid,
	input  wire logic          pop_ready,
	output      ptx_pkg::fr_t  pop_data
);

	ptx_pkg::fr_t                    mem_q [ptx_pkg::QDEPTH];
	logic [ptx_pkg::QPTR_W-1:0]      wr_q;
	logic [ptx_pkg::QPTR_W-1:0]      rd_q;
	logic [ptx_pkg::QPTR_W:0]        cnt_q;
	logic                            push;
	logic                            pop;

	assign push_ready = cnt_q != (ptx_pkg::QPTR_W+1)'(ptx_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

### rtl/ptx_colsum.sv
// ptx_colsum: three-stage multiply / accumulate for the four column sums
// depends on ptx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptx_colsum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire ptx_pkg::fr_t       in_data,
	input  wire ptx_pkg::cfg_regs_t mtx,
	output      logic               out_valid,
	output      ptx_pkg::cs_t       out_data
);

	ptx_pkg::dval_t                       pt [ptx_pkg::NIN];
	logic signed [ptx_pkg::PW-1:0]        prod_s1 [ptx_pkg::NCOL][ptx_pkg::NIN];
	logic signed [ptx_pkg::ACC_W-1:0]     sum_s2 [ptx_pkg::NCOL];
	ptx_pkg::sval_t                       col_s3 [ptx_pkg::NCOL];
	ptx_pkg::op_t                         op_s1, op_s2, op_s3;
	logic                                 v_s1, v_s2, v_s3;

	assign pt[0] = in_data.x;
	assign pt[1] = in_data.y;
	assign pt[2] = in_data.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_data.op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			for (int c = 0; c < ptx_pkg::NCOL; c++) begin
				for (int i = 0; i < ptx_pkg::NIN; i++) begin
					prod_s1[c][i] <= ptx_pkg::PW'(pt[i]) *
						ptx_pkg::PW'(ptx_pkg::coef(mtx, 2'(i), 2'(c)));
				end
				sum_s2[c] <= ptx_pkg::ACC_W'(prod_s1[c][0]) + ptx_pkg::ACC_W'(prod_s1[c][1])
					+ ptx_pkg::ACC_W'(prod_s1[c][2]);
				// floor of the exact sum, then the translation row
				col_s3[c] <= ptx_pkg::SW'(sum_s2[c] >>> ptx_pkg::FB)
					+ ptx_pkg::SW'(ptx_pkg::coef(mtx, 2'd3, 2'(c)));
			end
		end
	end

	assign out_valid   = v_s3;
	assign out_data.op = op_s3;
	always_comb begin
		for (int c = 0; c < ptx_pkg::NCOL; c++) out_data.s[c] = col_s3[c];
	end

endmodule

`default_nettype wire

### rtl/ptx_div.sv
// ptx_div: one output coordinate: bypass / saturate or pipelined restoring divide
// depends on ptx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptx_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire ptx_pkg::op_t   op,
	input  wire ptx_pkg::sval_t s,
	input  wire ptx_pkg::sval_t w,
	output      logic           out_valid,
	output      ptx_pkg::dval_t res,
	output      logic           clamp,
	output      logic           zero_w
);

	localparam int DW = ptx_pkg::DW;
	localparam int AW = ptx_pkg::AW;
	localparam int FB = ptx_pkg::FB;
	localparam logic [DW-1:0] QMAX    = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] QMINMAG = {1'b1, {(DW-1){1'b0}}};

	// prep
	logic            zw_c, byp_c, bclamp_c;
	ptx_pkg::dval_t  bres_c;
	logic [AW-1:0]   mag_c, dvs_c;

	logic            v_p, zw_p, byp_p, bclamp_p, neg_p;
	ptx_pkg::dval_t  bres_p;
	logic [AW-1:0]   mag_p, dvs_p;

	always_comb begin
		zw_c     = (op == ptx_pkg::OP_PERSP) && (w == '0);
		byp_c    = 1'b1;
		bclamp_c = 1'b0;
		bres_c   = ptx_pkg::dval_t'(s);
		if (op == ptx_pkg::OP_AFFINE) begin
			if (s > ptx_pkg::SMAX) begin
				bres_c   = ptx_pkg::DMAX;
				bclamp_c = 1'b1;
			end else if (s < ptx_pkg::SMIN) begin
				bres_c   = ptx_pkg::DMIN;
				bclamp_c = 1'b1;
			end
		end else if (zw_c) begin
			bclamp_c = s != '0;
			if (s[ptx_pkg::SW-1]) bres_c = ptx_pkg::DMIN;
			else if (s != '0)     bres_c = ptx_pkg::DMAX;
			else                  bres_c = '0;
		end else begin
			byp_c = 1'b0;
		end
		mag_c = s[ptx_pkg::SW-1] ? AW'(-s) : AW'(s);
		dvs_c = w[ptx_pkg::SW-1] ? AW'(-w) : AW'(w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p <= 1'b0;
		else if (en) v_p <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zw_p     <= zw_c;
			byp_p    <= byp_c;
			bclamp_p <= bclamp_c;
			bres_p   <= bres_c;
			neg_p    <= s[ptx_pkg::SW-1] ^ w[ptx_pkg::SW-1];
			mag_p    <= mag_c;
			dvs_p    <= dvs_c;
		end
	end

	// overflow check and the divide steps, one quotient bit per stage
	logic [AW+FB-1:0]     dvd;
	logic [ptx_pkg::HW-1:0] dvd_hi;

	logic [AW-1:0]   rem_q    [DW+1];
	logic [DW-1:0]   low_q    [DW+1];
	logic [DW-1:0]   quo_q    [DW+1];
	logic [AW-1:0]   dvs_q    [DW+1];
	logic            neg_q    [DW+1];
	logic            byp_q    [DW+1];
	logic            bclamp_q [DW+1];
	ptx_pkg::dval_t  bres_q   [DW+1];
	logic            zw_q     [DW+1];
	logic            ovf_q    [DW+1];
	logic            v_q      [DW+1];

	assign dvd    = {mag_p, {FB{1'b0}}};
	assign dvd_hi = dvd[AW+FB-1:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DW; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= v_p;
			for (int k = 0; k < DW; k++) v_q[k+1] <= v_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0]    <= ptx_pkg::CMP_W'(dvd_hi) >= ptx_pkg::CMP_W'(dvs_p);
			rem_q[0]    <= AW'(dvd_hi);
			low_q[0]    <= dvd[DW-1:0];
			quo_q[0]    <= '0;
			dvs_q[0]    <= dvs_p;
			neg_q[0]    <= neg_p;
			byp_q[0]    <= byp_p;
			bclamp_q[0] <= bclamp_p;
			bres_q[0]   <= bres_p;
			zw_q[0]     <= zw_p;
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_step
		logic [AW:0] trial;
		logic        ge;
		assign trial = {rem_q[k], low_q[k][DW-1]};
		assign ge    = trial >= {1'b0, dvs_q[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]    <= ge ? AW'(trial - {1'b0, dvs_q[k]}) : AW'(trial);
				low_q[k+1]    <= low_q[k] << 1;
				quo_q[k+1]    <= {quo_q[k][DW-2:0], ge};
				dvs_q[k+1]    <= dvs_q[k];
				neg_q[k+1]    <= neg_q[k];
				byp_q[k+1]    <= byp_q[k];
				bclamp_q[k+1] <= bclamp_q[k];
				bres_q[k+1]   <= bres_q[k];
				zw_q[k+1]     <= zw_q[k];
				ovf_q[k+1]    <= ovf_q[k];
			end
		end
	end

	// sign and final clamp
	logic            v_f_q, clamp_f_q, zw_f_q;
	ptx_pkg::dval_t  res_f_q;
	ptx_pkg::dval_t  res_c;
	logic            clamp_c;
	logic [DW-1:0]   q;

	assign q = quo_q[DW];

	always_comb begin
		res_c   = ptx_pkg::dval_t'(q);
		clamp_c = 1'b0;
		if (byp_q[DW]) begin
			res_c   = bres_q[DW];
			clamp_c = bclamp_q[DW];
		end else if (neg_q[DW]) begin
			if (ovf_q[DW] || q > QMINMAG) begin
				res_c   = ptx_pkg::DMIN;
				clamp_c = 1'b1;
			end else begin
				res_c = ptx_pkg::dval_t'(DW'(0) - q);
			end
		end else if (ovf_q[DW] || q > QMAX) begin
			res_c   = ptx_pkg::DMAX;
			clamp_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f_q <= 1'b0;
		else if (en) v_f_q <= v_q[DW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_f_q   <= res_c;
			clamp_f_q <= clamp_c;
			zw_f_q    <= zw_q[DW];
		end
	end

	assign out_valid = v_f_q;
	assign res       = res_f_q;
	assign clamp     = clamp_f_q;
	assign zero_w    = zw_f_q;

endmodule

`default_nettype wire

### rtl/point_transform_4x4.sv
// point_transform_4x4: top level, matrix registers, front/queue/back wiring
// depends on ptx_pkg, ptx_front, ptx_queue, ptx_colsum, ptx_div
//
//   channel | signals                          | handshake
//   --------+----------------------------------+---------------------------
//   in      | in_data (opcode, x/y/z_in)       | in_valid / in_ready
//   out     | out_data (x/y/z_out, flags)      | out_valid / out_ready
//   cfg     | cfg_idx, cfg_data                | cfg_we, no wait
//
// one beat per cycle while out_ready holds; a beat passes the front register, queue,
// column sums and the restoring divider, which makes one quotient bit per stage
// arst_n clears valid flags, queue pointers and the matrix (identity)
// the back pipeline stalls as a whole only while a result sits unaccepted;
// the front keeps taking beats until its register and the 2-entry queue fill
`timescale 1ns / 1ps
`default_nettype none

module point_transform_4x4 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire ptx_pkg::in_t                in_data,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      ptx_pkg::out_t               out_data,
	input  wire logic                        cfg_we,
	input  wire logic [ptx_pkg::IDX_W-1:0]   cfg_idx,
	input  wire logic [ptx_pkg::REG_W-1:0]   cfg_data
);

	// matrix registers
	ptx_pkg::cfg_regs_t mtx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptx_pkg::NREG; i++) begin
				mtx_q[i] <= ptx_pkg::reg_reset_val(ptx_pkg::reg_idx_t'(i));
			end
		end else if (cfg_we) begin
			mtx_q[cfg_idx] <= cfg_data;
		end
	end

	// front: capture and classify
	logic         fr_valid, fr_ready;
	ptx_pkg::fr_t fr_data;

	ptx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.fr_valid (fr_valid),
		.fr_ready (fr_ready),
		.fr_data  (fr_data)
	);

	// decoupling queue
	logic         bk_valid;
	logic         en;
	ptx_pkg::fr_t bk_data;

	ptx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (bk_valid),
		.pop_ready  (en),
		.pop_data   (bk_data)
	);

	// back pipeline advances unless the final result is held
	assign en = !out_valid || out_ready;

	logic         cs_valid;
	ptx_pkg::cs_t cs_data;

	ptx_colsum u_colsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (bk_valid),
		.in_data   (bk_data),
		.mtx       (mtx_q),
		.out_valid (cs_valid),
		.out_data  (cs_data)
	);

	// one divider lane per coordinate, w is column 3
	logic           lane_valid [ptx_pkg::NIN];
	ptx_pkg::dval_t lane_res   [ptx_pkg::NIN];
	logic           lane_clamp [ptx_pkg::NIN];
	logic           lane_zw    [ptx_pkg::NIN];

	for (genvar c = 0; c < ptx_pkg::NIN; c++) begin : g_lane
		ptx_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cs_valid),
			.op        (cs_data.op),
			.s         (cs_data.s[c]),
			.w         (cs_data.s[ptx_pkg::NCOL-1]),
			.out_valid (lane_valid[c]),
			.res       (lane_res[c]),
			.clamp     (lane_clamp[c]),
			.zero_w    (lane_zw[c])
		);
	end

	// lanes run in lockstep; zero_w and saturated are the OR over the lanes
	assign out_valid          = lane_valid[0] & lane_valid[1] & lane_valid[2];
	assign out_data.x_out     = ptx_pkg::IO_W'(lane_res[0]);
	assign out_data.y_out     = ptx_pkg::IO_W'(lane_res[1]);
	assign out_data.z_out     = ptx_pkg::IO_W'(lane_res[2]);
	assign out_data.zero_w    = lane_zw[0] | lane_zw[1] | lane_zw[2];
	assign out_data.saturated = lane_clamp[0] | lane_clamp[1] | lane_clamp[2];

endmodule

`default_nettype wire
